/* rtl/core/msd_pkg.sv */
// Package for the multiprecision short division block.
// Holds the register indexes, status codes, sequencer states and shared types.
// Used by msd_div_unit, multiprecision_short_division and the testbench; depends on nothing.
`default_nettype none

package msd_pkg;

  localparam int unsigned DigitW = 32;
  localparam int unsigned RadixW = 33;
  localparam int unsigned WideW  = 64;
  localparam int unsigned CntW   = 7;

  localparam logic [RadixW-1:0] RadixCap = 33'h1_0000_0000;

  localparam logic REG_RADIX   = 1'b0;
  localparam logic REG_DIVISOR = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_DIV_ZERO    = 2'd1,
    STAT_DIV_RANGE   = 2'd2,
    STAT_DIGIT_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_START,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              busy;
    logic [DigitW-1:0] quotient;
    logic [DigitW-1:0] remainder;
  } div_res_t;

endpackage

`default_nettype wire

/* rtl/core/multiprecision_short_division.sv */
// Top level of the multiprecision short division block.
// Depends on msd_pkg and msd_div_unit.
//
// Digits of a dividend enter on the input channel most significant first, and
// final_digit marks the last one. Each input transfer gives exactly one output
// transfer with the quotient digit, the status code and, on the last digit,
// the final remainder. The user must set radix and divisor through the write
// port only while the block is idle; the block itself does not enforce it.
// An item passes through the multiply, start and divide states to the done
// state; the radix-2 divider takes 32 steps, or 64 when the high half of the
// product word is not below the divisor. An item with an error skips these
// states and goes straight to the done state. The block accepts one item at a
// time and stalls its input while the item is in progress, until the sequencer
// returns to idle.
// The result sits in an output register, so a stalled receiver only holds the
// next item in its final state until the register frees up.
// Reset sets the radix to two to the 32, the divisor to one, and clears the
// running remainder, the error state and the output valid.
`default_nettype none

module multiprecision_short_division (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [msd_pkg::RadixW-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [msd_pkg::DigitW-1:0]    digit_i,
  input  wire logic                          final_digit_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [msd_pkg::DigitW-1:0]    quotient_digit_o,
  output      logic [msd_pkg::DigitW-1:0]    remainder_out_o,
  output      logic [1:0]                    status_o,
  output      logic                          end_of_number_o
);

  msd_pkg::state_e            state_q, state_d;
  msd_pkg::status_e           err_q, err_d;
  msd_pkg::status_e           stat_q, stat_d;
  msd_pkg::status_e           err_chk;
  logic [msd_pkg::RadixW-1:0] radix_q;
  logic [msd_pkg::DigitW-1:0] divisor_q;
  logic [msd_pkg::DigitW-1:0] rr_q, rr_d;
  logic [msd_pkg::DigitW-1:0] digit_q, digit_d;
  logic                       last_q, last_d;
  logic [msd_pkg::WideW-1:0]  v_q, v_d;
  logic [msd_pkg::WideW-1:0]  prod;
  logic [msd_pkg::RadixW-1:0] base;
  logic                       accept;
  logic                       out_load;
  logic                       div_start;
  msd_pkg::div_res_t          div_res;
  logic                       out_valid_q, out_valid_d;
  logic [msd_pkg::DigitW-1:0] quot_q, quot_d;
  logic [msd_pkg::DigitW-1:0] rem_out_q, rem_out_d;
  msd_pkg::status_e           stat_out_q, stat_out_d;
  logic                       eon_q, eon_d;

  assign base = (radix_q[msd_pkg::RadixW-1] && (radix_q[msd_pkg::DigitW-1:0] != '0))
              ? msd_pkg::RadixCap : radix_q;

  assign accept = in_valid_i && (state_q == msd_pkg::S_IDLE);

  always_comb begin
    if (err_q != msd_pkg::STAT_OK) begin
      err_chk = err_q;
    end else if (divisor_q == '0) begin
      err_chk = msd_pkg::STAT_DIV_ZERO;
    end else if ({1'b0, divisor_q} >= base) begin
      err_chk = msd_pkg::STAT_DIV_RANGE;
    end else if ({1'b0, digit_i} >= base) begin
      err_chk = msd_pkg::STAT_DIGIT_RANGE;
    end else begin
      err_chk = msd_pkg::STAT_OK;
    end
  end

  // A base of two to the 32 is a plain shift, so the multiplier stays 32 by 32.
  assign prod = base[msd_pkg::DigitW]
              ? {rr_q, {msd_pkg::DigitW{1'b0}}}
              : (msd_pkg::WideW'(rr_q) * msd_pkg::WideW'(base[msd_pkg::DigitW-1:0]));
  assign v_d  = prod + msd_pkg::WideW'(digit_q);

  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    stat_d      = stat_q;
    rr_d        = rr_q;
    digit_d     = digit_q;
    last_d      = last_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q;
    quot_d      = quot_q;
    rem_out_d   = rem_out_q;
    stat_out_d  = stat_out_q;
    eon_d       = eon_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      msd_pkg::S_IDLE: begin
        if (accept) begin
          digit_d = digit_i;
          last_d  = final_digit_i;
          stat_d  = err_chk;
          if (err_chk != msd_pkg::STAT_OK) begin
            rr_d    = '0;
            err_d   = final_digit_i ? msd_pkg::STAT_OK : err_chk;
            state_d = msd_pkg::S_DONE;
          end else begin
            state_d = msd_pkg::S_MUL;
          end
        end
      end
      msd_pkg::S_MUL: begin
        state_d = msd_pkg::S_START;
      end
      msd_pkg::S_START: begin
        div_start = 1'b1;
        state_d   = msd_pkg::S_DIV;
      end
      msd_pkg::S_DIV: begin
        if (!div_res.busy) begin
          state_d = msd_pkg::S_DONE;
        end
      end
      msd_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          stat_out_d  = stat_q;
          eon_d       = last_q;
          if (stat_q == msd_pkg::STAT_OK) begin
            quot_d    = div_res.quotient;
            rem_out_d = last_q ? div_res.remainder : '0;
            rr_d      = last_q ? '0 : div_res.remainder;
          end else begin
            quot_d    = '0;
            rem_out_d = '0;
          end
          state_d = msd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = msd_pkg::S_IDLE;
      end
    endcase
  end

  msd_div_unit u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (v_q),
    .divisor_i  (divisor_q),
    .res_o      (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msd_pkg::S_IDLE;
      err_q       <= msd_pkg::STAT_OK;
      rr_q        <= '0;
      radix_q     <= msd_pkg::RadixCap;
      divisor_q   <= msd_pkg::DigitW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      rr_q        <= rr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i == msd_pkg::REG_RADIX)) begin
        radix_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == msd_pkg::REG_DIVISOR)) begin
        divisor_q <= cfg_wdata_i[msd_pkg::DigitW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q    <= digit_d;
    last_q     <= last_d;
    stat_q     <= stat_d;
    quot_q     <= quot_d;
    rem_out_q  <= rem_out_d;
    stat_out_q <= stat_out_d;
    eon_q      <= eon_d;
    if (state_q == msd_pkg::S_MUL) begin
      v_q <= v_d;
    end
  end

  assign in_stall_o       = state_q != msd_pkg::S_IDLE;
  assign out_valid_o      = out_valid_q;
  assign quotient_digit_o = quot_q;
  assign remainder_out_o  = rem_out_q;
  assign status_o         = stat_out_q;
  assign end_of_number_o  = eon_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input not stalled after a transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o && (state_q == msd_pkg::S_IDLE))
    else $error("result load did not return the sequencer to idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != msd_pkg::STAT_OK)
      |-> (quotient_digit_o == '0) && (remainder_out_o == '0))
    else $error("error result carries nonzero data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !end_of_number_o |-> remainder_out_o == '0)
    else $error("remainder reported before the last digit");

endmodule

`default_nettype wire

/* rtl/core/msd_div_unit.sv */
// Radix-2 restoring divider: a 64-bit dividend by a 32-bit divisor, one bit per cycle.
// Keeps the low 32 quotient bits and the full remainder.
// Depends on msd_pkg.
`default_nettype none

module msd_div_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [msd_pkg::WideW-1:0]        dividend_i,
  input  wire logic [msd_pkg::DigitW-1:0]       divisor_i,
  output msd_pkg::div_res_t                     res_o
);

  logic [msd_pkg::DigitW-1:0] rem_q, rem_d;
  logic [msd_pkg::WideW-1:0]  sh_q, sh_d;
  logic [msd_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [msd_pkg::DigitW:0]   trial;
  logic [msd_pkg::DigitW:0]   diff;
  logic                       ge;
  logic                       hi_lt;

  assign trial = {rem_q, sh_q[msd_pkg::WideW-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};
  assign hi_lt = dividend_i[msd_pkg::WideW-1:msd_pkg::DigitW] < divisor_i;

  always_comb begin
    rem_d = rem_q;
    sh_d  = sh_q;
    cnt_d = cnt_q;
    if (start_i) begin
      if (hi_lt) begin
        // The high half is already a valid partial remainder.
        rem_d = dividend_i[msd_pkg::WideW-1:msd_pkg::DigitW];
        sh_d  = {dividend_i[msd_pkg::DigitW-1:0], {msd_pkg::DigitW{1'b0}}};
        cnt_d = msd_pkg::CntW'(msd_pkg::DigitW);
      end else begin
        rem_d = '0;
        sh_d  = dividend_i;
        cnt_d = msd_pkg::CntW'(msd_pkg::WideW);
      end
    end else if (cnt_q != '0) begin
      rem_d = ge ? diff[msd_pkg::DigitW-1:0] : trial[msd_pkg::DigitW-1:0];
      sh_d  = {sh_q[msd_pkg::WideW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign res_o = '{busy: (cnt_q != '0), quotient: sh_q[msd_pkg::DigitW-1:0], remainder: rem_q};

endmodule

`default_nettype wire

/* tb/short_division_checker.sv */
// Checker for the multiprecision short division block: watches the write port and
// both channels, predicts each result and compares it with the block's output.
// Depends on msd_pkg for the register indexes, status codes and widths.
module short_division_checker
  import msd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [RadixW-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  input  wire logic              in_stall_i,
  input  wire logic [DigitW-1:0] digit_i,
  input  wire logic              final_digit_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_stall_i,
  input  wire logic [DigitW-1:0] quotient_digit_i,
  input  wire logic [DigitW-1:0] remainder_out_i,
  input  wire logic [1:0]        status_i,
  input  wire logic              end_of_number_i,
  output int                     mismatches_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [DigitW-1:0] quotient;
    logic [DigitW-1:0] remainder;
    status_e           status;
    logic              last;
  } digit_result_t;

  logic [RadixW-1:0] radix_q = RadixCap;
  logic [DigitW-1:0] divisor_q = 32'd1;
  logic [DigitW-1:0] remainder_q = '0;
  status_e           error_q = STAT_OK;
  digit_result_t     expected_digits[$];

  function automatic digit_result_t divide_digit(input logic [DigitW-1:0] digit,
                                                 input logic last);
    logic [RadixW-1:0] base;
    logic [WideW-1:0]  value;
    digit_result_t     res;
    base = (radix_q > RadixCap) ? RadixCap : radix_q;
    if (error_q == STAT_OK) begin
      if (divisor_q == '0) begin
        error_q = STAT_DIV_ZERO;
      end else if ({1'b0, divisor_q} >= base) begin
        error_q = STAT_DIV_RANGE;
      end else if ({1'b0, digit} >= base) begin
        error_q = STAT_DIGIT_RANGE;
      end
      if (error_q != STAT_OK) begin
        remainder_q = '0;
      end
    end
    res = '0;
    res.status = error_q;
    res.last = last;
    if (error_q == STAT_OK) begin
      value = 64'(remainder_q) * 64'(base) + 64'(digit);
      res.quotient = 32'(value / 64'(divisor_q));
      remainder_q = 32'(value % 64'(divisor_q));
      if (last) begin
        res.remainder = remainder_q;
      end
    end
    if (last) begin
      remainder_q = '0;
      error_q = STAT_OK;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    digit_result_t exp;
    if (!rst_ni) begin
      radix_q = RadixCap;
      divisor_q = 32'd1;
      remainder_q = '0;
      error_q = STAT_OK;
      mismatches_o = 0;
      expected_digits.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_RADIX) begin
          radix_q = cfg_wdata_i;
        end else begin
          divisor_q = cfg_wdata_i[DigitW-1:0];
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_digits.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10) begin
            $display("unexpected result: quotient %h remainder %h status %0d end %0b",
                     quotient_digit_i, remainder_out_i, status_i, end_of_number_i);
          end
        end else begin
          exp = expected_digits.pop_front();
          if (quotient_digit_i !== exp.quotient || remainder_out_i !== exp.remainder ||
              status_i !== exp.status || end_of_number_i !== exp.last) begin
            mismatches_o++;
            if (mismatches_o <= 10) begin
              $display("mismatch: expected q %h r %h s %0d e %0b, got q %h r %h s %0d e %0b",
                       exp.quotient, exp.remainder, exp.status, exp.last,
                       quotient_digit_i, remainder_out_i, status_i, end_of_number_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_digits.insert(expected_digits.size(), divide_digit(digit_i, final_digit_i));
      end
    end
    pending_o = expected_digits.size();
  end

endmodule

/* tb/testbench.sv */
// Top of the testbench for the multiprecision short division block.
// Makes reset, configuration and digit stimulus, idles both channels at random
// and gives the verdict; depends on msd_pkg, multiprecision_short_division and short_division_checker.
module testbench;
  import msd_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned LongHold = 200;
  localparam int unsigned TotalItems = 24 + 1000;
  localparam int unsigned QuietItems = 100;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_idx = REG_RADIX;
  logic [RadixW-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [DigitW-1:0] digit = '0;
  logic              final_digit = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DigitW-1:0] quotient_digit;
  logic [DigitW-1:0] remainder_out;
  logic [1:0]        status;
  logic              end_of_number;
  int                mismatches;
  int                pending;

  logic [RadixW-1:0] radix_now = RadixCap;
  int unsigned       sent = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       send_gap_rate = 2;
  int unsigned       recv_stall_rate = 2;
  bit                quiet = 1'b0;
  bit                hold_request = 1'b0;
  bit                hold_done = 1'b0;

  always #5 clk = ~clk;

  multiprecision_short_division u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .digit_i          (digit),
    .final_digit_i    (final_digit),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .quotient_digit_o (quotient_digit),
    .remainder_out_o  (remainder_out),
    .status_o         (status),
    .end_of_number_o  (end_of_number)
  );

  short_division_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .digit_i          (digit),
    .final_digit_i    (final_digit),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .quotient_digit_i (quotient_digit),
    .remainder_out_i  (remainder_out),
    .status_i         (status),
    .end_of_number_i  (end_of_number),
    .mismatches_o     (mismatches),
    .pending_o        (pending)
  );

  function automatic logic [RadixW-1:0] base_now();
    return (radix_now > RadixCap) ? RadixCap : radix_now;
  endfunction

  function automatic logic [DigitW-1:0] random_digit();
    logic [RadixW-1:0] base;
    base = base_now();
    if (base <= 1 || base >= RadixCap || $urandom_range(0, 19) == 0) begin
      return $urandom;
    end
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'(base - 1);
      default: return $urandom_range(0, 32'(base - 1));
    endcase
  endfunction

  function automatic logic [DigitW-1:0] random_divisor(input logic [RadixW-1:0] base);
    case ($urandom_range(0, 9))
      0: return '0;
      1: begin
        if (base >= RadixCap) begin
          return 32'hFFFF_FFFF;
        end
        return $urandom_range(32'(base), 32'hFFFF_FFFF);
      end
      2: return 32'd1;
      3: return (base >= 2) ? 32'(base - 1) : 32'd1;
      default: return (base >= 2) ? $urandom_range(1, 32'(base - 1)) : $urandom;
    endcase
  endfunction

  // Registers are only written once every expected result has been transferred.
  task automatic write_config(input bit with_radix, input logic [RadixW-1:0] radix,
                              input logic [RadixW-1:0] divisor_word);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    if (with_radix) begin
      cfg_we <= 1'b1;
      cfg_idx <= REG_RADIX;
      cfg_wdata <= radix;
      radix_now = radix;
      @(negedge clk);
    end
    cfg_we <= 1'b1;
    cfg_idx <= REG_DIVISOR;
    cfg_wdata <= divisor_word;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drive_digit(input logic [DigitW-1:0] value, input logic last);
    if (!quiet && $urandom_range(0, 7) < send_gap_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    digit <= value;
    final_digit <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_number(input int unsigned len, input bit split);
    for (int unsigned i = 0; i < len; i++) begin
      drive_digit(random_digit(), i == len - 1);
      if (split && i == 0 && len > 1) begin
        write_config(1'b0, '0, {1'($urandom), random_divisor(base_now())});
      end
    end
  endtask

  function automatic logic [RadixW-1:0] random_radix();
    logic [RadixW-1:0] radix;
    case ($urandom_range(0, 9))
      0, 1, 2: radix = RadixCap;
      3, 4: radix = 33'($urandom_range(2, 16));
      5, 6, 7: begin
        radix = {1'b0, $urandom};
        if (radix < 2) begin
          radix = 33'd2;
        end
      end
      8: radix = 33'($urandom_range(0, 1));
      default: radix = {1'b1, $urandom};
    endcase
    return radix;
  endfunction

  initial begin
    logic [RadixW-1:0] radix;
    logic [RadixW-1:0] base;
    int unsigned       numbers;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    drive_digit(32'h0, 1'b0);
    drive_digit(32'hFFFF_FFFF, 1'b1);
    write_config(1'b0, '0, 33'h0_FFFF_FFFF);
    drive_digit(32'hFFFF_FFFE, 1'b0);
    drive_digit(32'hFFFF_FFFF, 1'b0);
    drive_digit(32'h1234_5678, 1'b1);
    write_config(1'b0, '0, 33'd0);
    drive_digit(32'd5, 1'b0);
    drive_digit(32'd6, 1'b1);
    write_config(1'b1, 33'd10, 33'd10);
    drive_digit(32'd3, 1'b1);
    // A digit out of range in the middle of a number poisons the rest of it.
    write_config(1'b0, '0, 33'd7);
    drive_digit(32'd9, 1'b0);
    drive_digit(32'd10, 1'b0);
    drive_digit(32'd3, 1'b1);
    drive_digit(32'd6, 1'b0);
    drive_digit(32'd9, 1'b0);
    drive_digit(32'd4, 1'b1);
    write_config(1'b1, 33'd1, 33'd1);
    drive_digit(32'd0, 1'b1);
    write_config(1'b1, 33'd0, 33'd0);
    drive_digit(32'd0, 1'b1);
    write_config(1'b0, '0, 33'd5);
    drive_digit(32'd1, 1'b1);
    write_config(1'b1, 33'h1_FFFF_FFFF, 33'h1_0000_0003);
    drive_digit(32'hFFFF_FFFF, 1'b0);
    drive_digit(32'hFFFF_FFFF, 1'b1);
    // Shrinking the divisor mid-number leaves a remainder above it.
    write_config(1'b1, RadixCap, 33'h0_FFFF_FFFF);
    drive_digit(32'hFFFF_FFFE, 1'b0);
    write_config(1'b0, '0, 33'd2);
    drive_digit(32'd5, 1'b1);
    write_config(1'b1, 33'd2, 33'd1);
    drive_digit(32'd1, 1'b0);
    drive_digit(32'd0, 1'b0);
    drive_digit(32'd1, 1'b1);

    while (sent < TotalItems) begin
      quiet = (sent + QuietItems >= TotalItems);
      send_gap_rate = $urandom_range(0, 4);
      recv_stall_rate = $urandom_range(0, 4);
      radix = random_radix();
      base = (radix > RadixCap) ? RadixCap : radix;
      write_config(1'b1, radix, {1'($urandom), random_divisor(base)});
      if (!hold_done && sent >= 400) begin
        hold_done = 1'b1;
        hold_request = 1'b1;
        send_gap_rate = 0;
        send_number(12, 1'b0);
      end
      numbers = $urandom_range(1, 4);
      repeat (numbers) begin
        send_number(($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6),
                    $urandom_range(0, 9) == 0);
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LongHold) @(negedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) < recv_stall_rate) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule

/* sim.f */
rtl/core/msd_pkg.sv
rtl/core/msd_div_unit.sv
rtl/core/multiprecision_short_division.sv
tb/short_division_checker.sv
tb/testbench.sv
